// File: rtl/srecord_loader_defines.svh
// Assertion macros shared by the S-record loader checker.
`ifndef SRECORD_LOADER_DEFINES_SVH
`define SRECORD_LOADER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define SRL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srl_pkg.sv
// Package with types, constants and helper functions of the S-record loader.
`timescale 1ns / 1ps

package srl_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_7    = 8'h37;
    localparam logic [7:0] CH_8    = 8'h38;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] SUM_OK0 = 8'h00;
    localparam logic [7:0] SUM_OK1 = 8'hff;

    localparam logic [3:0] REC_NONE = 4'd0;
    localparam logic [3:0] REC_S1   = 4'd1;
    localparam logic [3:0] REC_S2   = 4'd2;
    localparam logic [3:0] REC_S3   = 4'd3;
    localparam logic [3:0] REC_S7   = 4'd7;
    localparam logic [3:0] REC_S8   = 4'd8;
    localparam logic [3:0] REC_S9   = 4'd9;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Classified character as it travels from the front to the back.
    typedef struct packed {
        logic       is_s;
        logic [3:0] type_code;
        logic [3:0] nibble;
        logic       last;
    } t_token;

    typedef struct packed {
        logic        kind;
        logic [31:0] write_addr;
        logic [7:0]  write_byte;
        logic [31:0] start_addr;
        logic        start_seen;
        logic [31:0] end_addr;
        logic [31:0] entry_addr;
        logic        sum_error;
        logic [31:0] error_addr;
    } t_result;

    // Non-hex characters count as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        return v;
    endfunction

    function automatic logic [3:0] type_code(input logic [7:0] c);
        logic [3:0] t;
        case (c)
            CH_1:    t = REC_S1;
            CH_2:    t = REC_S2;
            CH_3:    t = REC_S3;
            CH_7:    t = REC_S7;
            CH_8:    t = REC_S8;
            CH_9:    t = REC_S9;
            default: t = REC_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] addr_size(input logic [3:0] t);
        logic [2:0] n;
        case (t)
            REC_S1, REC_S9: n = 3'd2;
            REC_S2, REC_S8: n = 3'd3;
            REC_S3, REC_S7: n = 3'd4;
            default:        n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_data(input logic [3:0] t);
        return (t == REC_S1) || (t == REC_S2) || (t == REC_S3);
    endfunction

    function automatic logic is_end(input logic [3:0] t);
        return (t == REC_S7) || (t == REC_S8) || (t == REC_S9);
    endfunction

endpackage

// File: rtl/srl_char_if.sv
// Stream interface carrying received characters.
`timescale 1ns / 1ps

interface srl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_last;

    modport source (output valid, ch, line_last, input ready);
    modport sink   (input valid, ch, line_last, output ready);
endinterface

// File: rtl/srl_res_if.sv
// Stream interface carrying loader results (byte writes and load summaries).
`timescale 1ns / 1ps

interface srl_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] write_addr;
    logic [7:0]  write_byte;
    logic [31:0] start_addr;
    logic        start_seen;
    logic [31:0] end_addr;
    logic [31:0] entry_addr;
    logic        sum_error;
    logic [31:0] error_addr;

    modport source (output valid, kind, write_addr, write_byte, start_addr, start_seen,
                    end_addr, entry_addr, sum_error, error_addr, input ready);
    modport sink   (input valid, kind, write_addr, write_byte, start_addr, start_seen,
                    end_addr, entry_addr, sum_error, error_addr, output ready);
endinterface

// File: rtl/srl_front.sv
// Front end: accepts characters and classifies them into tokens.
`timescale 1ns / 1ps

module srl_front (
    srl_char_if.sink         i_char,
    output logic             o_tok_valid,
    output srl_pkg::t_token  o_tok,
    input  logic             i_tok_ready
);

    assign i_char.ready   = i_tok_ready;
    assign o_tok_valid    = i_char.valid;
    assign o_tok.is_s      = (i_char.ch == srl_pkg::CH_S);
    assign o_tok.type_code = srl_pkg::type_code(i_char.ch);
    assign o_tok.nibble    = srl_pkg::hex_value(i_char.ch);
    assign o_tok.last      = i_char.line_last;

endmodule

// File: rtl/srl_queue.sv
// Short token queue between the front end and the record engine.
`timescale 1ns / 1ps

module srl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  srl_pkg::t_token  i_push_tok,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output srl_pkg::t_token  o_pop_tok,
    input  logic             i_pop_ready
);

    localparam int AW = srl_pkg::QUEUE_AW;
    localparam logic [AW-1:0] LAST_IDX = AW'(srl_pkg::QUEUE_DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW + 1)'(srl_pkg::QUEUE_DEPTH);

    srl_pkg::t_token r_mem [srl_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_tok    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/srl_back.sv
// Record engine: runs the S-record parse state and drives the result register.
`timescale 1ns / 1ps

module srl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    input  srl_pkg::t_token  i_tok,
    output logic             o_tok_ready,
    srl_res_if.source        o_res
);

    localparam logic [2:0] PH_LINE_START = 3'd0;
    localparam logic [2:0] PH_SKIP       = 3'd1;
    localparam logic [2:0] PH_TYPE       = 3'd2;
    localparam logic [2:0] PH_COUNT      = 3'd3;
    localparam logic [2:0] PH_BODY       = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_hi, n_hi;
    logic        r_odd, n_odd;
    logic [3:0]  r_rtype, n_rtype;
    logic [7:0]  r_bl, n_bl;
    logic [2:0]  r_abl, n_abl;
    logic [7:0]  r_sum, n_sum;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_wp, n_wp;
    logic [31:0] r_rsp, n_rsp;
    logic [31:0] r_fa, n_fa;
    logic        r_fs, n_fs;
    logic [31:0] r_entry, n_entry;
    logic        r_err, n_err;
    logic [31:0] r_eptr, n_eptr;

    logic              r_out_valid;
    srl_pkg::t_result  r_out;
    srl_pkg::t_result  n_res;
    logic              n_emit;
    logic              consume;
    logic [7:0]        byte_val;

    assign consume     = i_tok_valid && (!r_out_valid || o_res.ready);
    assign o_tok_ready = consume;
    assign byte_val    = {r_hi, i_tok.nibble};

    always_comb begin
        n_phase = r_phase;
        n_hi    = r_hi;
        n_odd   = r_odd;
        n_rtype = r_rtype;
        n_bl    = r_bl;
        n_abl   = r_abl;
        n_sum   = r_sum;
        n_acc   = r_acc;
        n_wp    = r_wp;
        n_rsp   = r_rsp;
        n_fa    = r_fa;
        n_fs    = r_fs;
        n_entry = r_entry;
        n_err   = r_err;
        n_eptr  = r_eptr;
        n_emit  = 1'b0;
        n_res   = '0;

        if (consume) begin
            case (r_phase)
                PH_LINE_START: begin
                    if (i_tok.is_s) begin
                        n_phase = PH_TYPE;
                        n_rsp   = r_wp;
                        n_sum   = '0;
                        n_odd   = 1'b0;
                        n_hi    = '0;
                        n_bl    = '0;
                        n_abl   = '0;
                        n_acc   = '0;
                        n_rtype = srl_pkg::REC_NONE;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                end
                PH_TYPE: begin
                    n_rtype = i_tok.type_code;
                    n_phase = PH_COUNT;
                end
                PH_COUNT, PH_BODY: begin
                    if (!r_odd) begin
                        n_hi  = i_tok.nibble;
                        n_odd = 1'b1;
                    end else begin
                        n_odd = 1'b0;
                        if (r_phase == PH_COUNT) begin
                            n_sum   = byte_val;
                            n_bl    = byte_val;
                            n_abl   = srl_pkg::addr_size(r_rtype);
                            n_acc   = '0;
                            n_phase = PH_BODY;
                        end else if (r_abl != '0) begin
                            // address byte: shift in, sum only within the count
                            n_acc = {r_acc[23:0], byte_val};
                            n_abl = r_abl - 3'd1;
                            if (r_bl != '0) begin
                                n_sum = r_sum + byte_val;
                                n_bl  = r_bl - 8'd1;
                            end
                            if (r_abl == 3'd1) begin
                                if (srl_pkg::is_data(r_rtype)) begin
                                    n_wp = n_acc;
                                    if (!r_fs) begin
                                        n_fa = n_acc;
                                        n_fs = 1'b1;
                                    end
                                end else if (srl_pkg::is_end(r_rtype)) begin
                                    n_entry = n_acc;
                                end
                            end
                        end else if (r_bl != '0) begin
                            // data byte, or the checksum when it is the last one
                            n_sum = r_sum + byte_val;
                            n_bl  = r_bl - 8'd1;
                            if (n_bl != '0 && srl_pkg::is_data(r_rtype)) begin
                                n_emit           = 1'b1;
                                n_res.kind       = srl_pkg::KIND_WRITE;
                                n_res.write_addr = r_wp;
                                n_res.write_byte = byte_val;
                                n_wp             = r_wp + 32'd1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            if (i_tok.last) begin
                if (n_phase == PH_COUNT || n_phase == PH_BODY) begin
                    if (n_sum != srl_pkg::SUM_OK0 && n_sum != srl_pkg::SUM_OK1) begin
                        n_err  = 1'b1;
                        n_eptr = n_rsp;
                    end
                    if (srl_pkg::is_end(n_rtype)) begin
                        if (n_abl != '0) begin
                            n_entry = n_acc;
                        end
                        n_emit           = 1'b1;
                        n_res            = '0;
                        n_res.kind       = srl_pkg::KIND_SUMMARY;
                        n_res.start_addr = n_fa;
                        n_res.start_seen = n_fs;
                        n_res.end_addr   = n_wp;
                        n_res.entry_addr = n_entry;
                        n_res.sum_error  = n_err;
                        n_res.error_addr = n_err ? n_eptr : 32'd0;
                        // return to the reset state for a fresh load
                        n_hi    = '0;
                        n_rtype = srl_pkg::REC_NONE;
                        n_bl    = '0;
                        n_abl   = '0;
                        n_sum   = '0;
                        n_acc   = '0;
                        n_wp    = '0;
                        n_rsp   = '0;
                        n_fa    = '0;
                        n_fs    = 1'b0;
                        n_entry = '0;
                        n_err   = 1'b0;
                        n_eptr  = '0;
                    end
                end
                n_phase = PH_LINE_START;
                n_odd   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE_START;
            r_hi        <= '0;
            r_odd       <= 1'b0;
            r_rtype     <= srl_pkg::REC_NONE;
            r_bl        <= '0;
            r_abl       <= '0;
            r_sum       <= '0;
            r_acc       <= '0;
            r_wp        <= '0;
            r_rsp       <= '0;
            r_fa        <= '0;
            r_fs        <= 1'b0;
            r_entry     <= '0;
            r_err       <= 1'b0;
            r_eptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_hi    <= n_hi;
            r_odd   <= n_odd;
            r_rtype <= n_rtype;
            r_bl    <= n_bl;
            r_abl   <= n_abl;
            r_sum   <= n_sum;
            r_acc   <= n_acc;
            r_wp    <= n_wp;
            r_rsp   <= n_rsp;
            r_fa    <= n_fa;
            r_fs    <= n_fs;
            r_entry <= n_entry;
            r_err   <= n_err;
            r_eptr  <= n_eptr;
            if (consume && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && n_emit) begin
            r_out <= n_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out.kind;
    assign o_res.write_addr = r_out.write_addr;
    assign o_res.write_byte = r_out.write_byte;
    assign o_res.start_addr = r_out.start_addr;
    assign o_res.start_seen = r_out.start_seen;
    assign o_res.end_addr   = r_out.end_addr;
    assign o_res.entry_addr = r_out.entry_addr;
    assign o_res.sum_error  = r_out.sum_error;
    assign o_res.error_addr = r_out.error_addr;

endmodule

// File: rtl/srecord_loader.sv
// Top level of the S-record loader: front end, token queue and record engine.
`timescale 1ns / 1ps
//
//  channel   dir   transfer when        payload
//  i_char    in    valid && ready       ch[7:0], line_last
//  o_res     out   valid && ready       kind, write_addr, write_byte, start_addr,
//                                       start_seen, end_addr, entry_addr,
//                                       sum_error, error_addr
//
//  One character per cycle sustained while o_res takes results. A character is
//  registered in its queue entry, and its result is then registered in the result
//  register that drives o_res.
//  The rate is set by the record engine, which updates its parse state once per token.
//  Synchronous active-low reset clears all parse state and empties the queue at once.
//  A stalled result holds in the output register and stops the engine; the
//  four-entry queue takes up to four more transfers before i_char.ready drops.

module srecord_loader (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srl_char_if.sink   i_char,
    srl_res_if.source  o_res
);

    // Front end to queue
    logic             front_valid;
    logic             front_ready;
    srl_pkg::t_token  front_tok;

    // Queue to record engine
    logic             q_valid;
    logic             q_ready;
    srl_pkg::t_token  q_tok;

    // Classify each character: 'S' marker, record type digit, hex nibble.
    srl_front u_front (
        .i_char      (i_char),
        .o_tok_valid (front_valid),
        .o_tok       (front_tok),
        .i_tok_ready (front_ready)
    );

    // Decouple the character side from result stalls.
    srl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_tok   (front_tok),
        .o_push_ready (front_ready),
        .o_pop_valid  (q_valid),
        .o_pop_tok    (q_tok),
        .i_pop_ready  (q_ready)
    );

    // Walk the record fields, emit byte writes and the final load summary.
    srl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_tok_ready (q_ready),
        .o_res       (o_res)
    );

endmodule

// File: rtl/srl_checker.sv
// Port-level checker for the S-record loader and its bind to the top level.
`timescale 1ns / 1ps
`include "srecord_loader_defines.svh"

module srl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_kind,
    input logic [31:0] i_write_addr,
    input logic [7:0]  i_write_byte,
    input logic        i_start_seen,
    input logic [31:0] i_end_addr,
    input logic        i_sum_error,
    input logic [31:0] i_error_addr
);

    `SRL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_kind) && $stable(i_write_addr) && $stable(i_write_byte),
        "stalled result changed")

    `SRL_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !i_out_valid,
        "result valid after reset")

    `SRL_ASSERT_NOW(a_write_clean, i_clk, i_rst_n, i_out_valid && !i_kind,
        !i_sum_error && !i_start_seen && i_error_addr == 32'd0 && i_end_addr == 32'd0,
        "write carries summary fields")

    `SRL_ASSERT_NOW(a_summary_clean, i_clk, i_rst_n, i_out_valid && i_kind,
        i_write_addr == 32'd0 && i_write_byte == 8'd0 && (i_sum_error || i_error_addr == 32'd0),
        "summary carries stray fields")

endmodule

bind srecord_loader srl_checker u_srl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_kind       (o_res.kind),
    .i_write_addr (o_res.write_addr),
    .i_write_byte (o_res.write_byte),
    .i_start_seen (o_res.start_seen),
    .i_end_addr   (o_res.end_addr),
    .i_sum_error  (o_res.sum_error),
    .i_error_addr (o_res.error_addr)
);
